/* sv/pinp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinp_pkg
// Shared types and constants for the palette-indexed nibble packer.
// ----------------------------------------------------------------------------
package pinp_pkg;

  localparam int PALETTE_SIZE_DEFAULT = 16;
  localparam int COLOR_W              = 24;
  localparam int INDEX_W              = 4;
  localparam int ENTRY_W              = 4;
  localparam int COUNT_W              = 5;
  localparam int BYTE_W               = 8;
  localparam int KIND_W               = 2;

  localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COLOR_W-1:0] color;
    logic [ENTRY_W-1:0] entry;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  packed_byte;
    logic               byte_valid;
    logic [INDEX_W-1:0] index;
    logic               found;
    logic               new_entry;
    logic               overflow;
    logic [COUNT_W-1:0] color_count;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
  } out_t;

  // Lookup status from the palette store to the result logic
  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] match_idx;
    logic               append_ok;
    logic [COUNT_W-1:0] used;
    logic               rd_ok;
    logic [COLOR_W-1:0] rd_color;
  } pal_info_t;

endpackage
`default_nettype wire

/* sv/pinp_palette.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinp_palette
// Palette store: parallel compare with lowest-index match, append on
// learn miss, and entry read-out.
// ----------------------------------------------------------------------------
module pinp_palette #(
  parameter int PALETTE_SIZE = pinp_pkg::PALETTE_SIZE_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire pinp_pkg::in_t       item,
  output pinp_pkg::pal_info_t      info
);

  localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  logic [pinp_pkg::COLOR_W-1:0] palette [PALETTE_SIZE];
  logic [pinp_pkg::COUNT_W-1:0] used_count;
  logic                         write_en;

  always_comb begin
    info           = '0;
    info.used      = used_count;
    info.append_ok = used_count < pinp_pkg::COUNT_W'(PALETTE_SIZE);
    for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
      if ((pinp_pkg::COUNT_W'(i) < used_count) && (palette[i] == item.color)) begin
        info.hit       = 1'b1;
        info.match_idx = pinp_pkg::INDEX_W'(i);
      end
    end
    info.rd_ok = {1'b0, item.entry} < used_count;
    if (info.rd_ok) begin
      info.rd_color = palette[item.entry[AW-1:0]];
    end
  end

  assign write_en = fire && (item.kind == pinp_pkg::KIND_LEARN) && !info.hit
                    && info.append_ok;

  always_ff @(posedge clk) begin
    if (write_en) begin
      palette[used_count[AW-1:0]] <= item.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (write_en) begin
      used_count <= used_count + pinp_pkg::COUNT_W'(1);
    end
  end

endmodule
`default_nettype wire

/* sv/pinp_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinp_packer
// Packs two 4-bit indices per byte, first in the low nibble; flush
// emits a pending odd nibble.
// ----------------------------------------------------------------------------
module pinp_packer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [pinp_pkg::KIND_W-1:0]   kind,
  input  wire logic [pinp_pkg::INDEX_W-1:0]  idx,
  output logic      [pinp_pkg::BYTE_W-1:0]   packed_byte,
  output logic                               byte_valid
);

  logic                         nibble_pending;
  logic                         nibble_pending_next;
  logic [pinp_pkg::INDEX_W-1:0] low_nibble;
  logic [pinp_pkg::INDEX_W-1:0] low_nibble_next;

  always_comb begin
    packed_byte         = '0;
    byte_valid          = 1'b0;
    nibble_pending_next = nibble_pending;
    low_nibble_next     = low_nibble;
    case (kind)
      pinp_pkg::KIND_ENCODE: begin
        if (nibble_pending) begin
          packed_byte         = {idx, low_nibble};
          byte_valid          = 1'b1;
          nibble_pending_next = 1'b0;
          low_nibble_next     = '0;
        end else begin
          nibble_pending_next = 1'b1;
          low_nibble_next     = idx;
        end
      end
      pinp_pkg::KIND_FLUSH: begin
        if (nibble_pending) begin
          packed_byte         = {{(pinp_pkg::BYTE_W - pinp_pkg::INDEX_W){1'b0}}, low_nibble};
          byte_valid          = 1'b1;
          nibble_pending_next = 1'b0;
          low_nibble_next     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_pending <= 1'b0;
      low_nibble     <= '0;
    end else if (fire) begin
      nibble_pending <= nibble_pending_next;
      low_nibble     <= low_nibble_next;
    end
  end

endmodule
`default_nettype wire

/* sv/palette_indexed_nibble_packer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_indexed_nibble_packer_core
// Learns a palette of 24-bit colors and encodes pixels as packed 4-bit
// indices; also flushes odd nibbles and reads palette entries.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+------------------
//   item     | item_valid, item_stall, item     | pinp_pkg::in_t
//   result   | result_valid, result_stall, result | pinp_pkg::out_t
//
// One item per cycle while result_stall is low; an item passes the input
// register, then compare/pack logic into the result register.
// State (palette, count, pending nibble) is updated as the item moves into
// the result register, so the next item always sees it.
// Reset empties both registers, clears the count and the pending nibble.
// result_stall holds result and a full input register; comb. to item_stall.
// ----------------------------------------------------------------------------
module palette_indexed_nibble_packer_core #(
  parameter int PALETTE_SIZE = pinp_pkg::PALETTE_SIZE_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire pinp_pkg::in_t   item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output pinp_pkg::out_t       result
);

  logic                s1_valid;
  pinp_pkg::in_t       s1_item;
  logic                s1_fire;
  logic                out_free;
  pinp_pkg::pal_info_t info;
  pinp_pkg::out_t      result_next;
  logic [pinp_pkg::INDEX_W-1:0] pack_idx;
  logic [pinp_pkg::BYTE_W-1:0]  packed_byte;
  logic                         byte_valid;

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  pinp_palette #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_palette (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .info (info)
  );

  assign pack_idx = info.hit ? info.match_idx : '0;

  pinp_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .kind        (s1_item.kind),
    .idx         (pack_idx),
    .packed_byte (packed_byte),
    .byte_valid  (byte_valid)
  );

  always_comb begin
    result_next             = '0;
    result_next.packed_byte = packed_byte;
    result_next.byte_valid  = byte_valid;
    result_next.color_count = info.used;
    unique case (s1_item.kind)
      pinp_pkg::KIND_LEARN: begin
        if (info.hit) begin
          result_next.index = info.match_idx;
          result_next.found = 1'b1;
        end else if (info.append_ok) begin
          result_next.index       = info.used[pinp_pkg::INDEX_W-1:0];
          result_next.new_entry   = 1'b1;
          result_next.color_count = info.used + pinp_pkg::COUNT_W'(1);
        end else begin
          result_next.overflow = 1'b1;
        end
      end
      pinp_pkg::KIND_ENCODE: begin
        result_next.index = pack_idx;
        result_next.found = info.hit;
      end
      pinp_pkg::KIND_FLUSH: begin
      end
      pinp_pkg::KIND_READ: begin
        result_next.index = s1_item.entry;
        result_next.found = info.rd_ok;
        result_next.red   = info.rd_color[7:0];
        result_next.green = info.rd_color[15:8];
        result_next.blue  = info.rd_color[23:16];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_palette_indexed_nibble_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_indexed_nibble_packer_core
// Self-checking bench for the palette nibble packer. A short directed run
// covers the empty palette, a flush with no nibble pending, unmatched encodes,
// learning while a nibble is pending, and reads past the entries in use.
// Random items follow: mostly learns and encodes that reuse known colors, so
// the palette fills and then overflows. Both sides idle at random. Every
// accepted item is run through a local palette/packer model, and each result
// is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_palette_indexed_nibble_packer_core;

  localparam int     PAL_SIZE     = pinp_pkg::PALETTE_SIZE_DEFAULT;
  localparam int     RANDOM_ITEMS = 550;
  localparam int     DRAIN_EVERY  = 180;
  localparam longint TIMEOUT_NS   = 5_000_000;

  typedef struct {
    pinp_pkg::in_t payload;
    bit            drain_first;
  } queued_item_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           item_valid = 1'b0;
  logic           item_stall;
  pinp_pkg::in_t  item = '0;
  logic           result_valid;
  logic           result_stall = 1'b0;
  pinp_pkg::out_t result;

  queued_item_t                 item_queue[$];
  pinp_pkg::out_t               expected_results[$];
  logic [pinp_pkg::COLOR_W-1:0] learn_pool[$];

  logic [pinp_pkg::COLOR_W-1:0] shadow_palette[16];
  logic [pinp_pkg::COUNT_W-1:0] shadow_count   = '0;
  logic                         shadow_pending = 1'b0;
  logic [pinp_pkg::INDEX_W-1:0] shadow_low     = '0;

  bit item_taken     = 1'b0;
  int idle_left      = 0;
  int steady_items   = 0;
  int stall_left     = 0;
  int steady_cycles  = 0;
  int mismatch_count = 0;

  palette_indexed_nibble_packer_core #(
    .PALETTE_SIZE(PAL_SIZE)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #10 clk = ~clk;

  // Palette lookup/append and nibble packing for one item; updates shadow state.
  function automatic pinp_pkg::out_t palette_step(pinp_pkg::in_t it);
    pinp_pkg::out_t               r;
    logic                         hit;
    logic [pinp_pkg::INDEX_W-1:0] idx;
    int                           k;
    r   = '0;
    hit = 1'b0;
    idx = '0;
    for (k = 0; k < int'(shadow_count); k++) begin
      if (!hit && shadow_palette[k] == it.color) begin
        hit = 1'b1;
        idx = pinp_pkg::INDEX_W'(k);
      end
    end
    case (it.kind)
      pinp_pkg::KIND_LEARN: begin
        if (hit) begin
          r.found = 1'b1;
        end else if (shadow_count < PAL_SIZE) begin
          idx = pinp_pkg::INDEX_W'(shadow_count);
          shadow_palette[idx] = it.color;
          shadow_count = shadow_count + pinp_pkg::COUNT_W'(1);
          r.new_entry = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
        r.index = idx;
      end
      pinp_pkg::KIND_ENCODE: begin
        r.index = idx;
        r.found = hit;
        if (shadow_pending) begin
          r.packed_byte  = {idx, shadow_low};
          r.byte_valid   = 1'b1;
          shadow_pending = 1'b0;
          shadow_low     = '0;
        end else begin
          shadow_low     = idx;
          shadow_pending = 1'b1;
        end
      end
      pinp_pkg::KIND_FLUSH: begin
        if (shadow_pending) begin
          r.packed_byte  = {4'h0, shadow_low};
          r.byte_valid   = 1'b1;
          shadow_pending = 1'b0;
          shadow_low     = '0;
        end
      end
      pinp_pkg::KIND_READ: begin
        r.index = it.entry;
        if (it.entry < shadow_count) begin
          r.found = 1'b1;
          {r.blue, r.green, r.red} = shadow_palette[it.entry];
        end
      end
      default: ;
    endcase
    r.color_count = shadow_count;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [pinp_pkg::COLOR_W-1:0] any_color();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return pinp_pkg::COLOR_W'($urandom);
    endcase
  endfunction

  task automatic add_item(logic [pinp_pkg::KIND_W-1:0] kind,
                          logic [pinp_pkg::COLOR_W-1:0] color,
                          logic [pinp_pkg::ENTRY_W-1:0] entry, bit drain_first);
    queued_item_t q;
    q.payload.kind  = kind;
    q.payload.color = color;
    q.payload.entry = entry;
    q.drain_first   = drain_first;
    item_queue.insert(item_queue.size(), q);
    if (kind == pinp_pkg::KIND_LEARN) learn_pool.insert(learn_pool.size(), color);
  endtask

  task automatic flag_error(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR @%0t %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Item driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_taken || !item_valid) begin
      item_taken = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
        item_valid <= 1'b0;
      end else if (item_queue.size() == 0 ||
                   (item_queue[0].drain_first && expected_results.size() != 0)) begin
        item_valid <= 1'b0;
      end else begin
        item       <= item_queue[0].payload;
        item_valid <= 1'b1;
        void'(item_queue.pop_front());
        if (steady_items > 0) begin
          steady_items--;
          idle_left = 0;
        end else begin
          idle_left = pick_gap();
          if ($urandom_range(0, 24) == 0) steady_items = $urandom_range(15, 40);
        end
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (steady_cycles > 0) begin
        steady_cycles--;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(0, 24) == 0) steady_cycles = $urandom_range(20, 60);
      end
    end
  end

  // Monitor: check results first, then predict for the item taken this edge
  always @(posedge clk) begin
    pinp_pkg::out_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          flag_error("result with nothing expected", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (result.packed_byte !== want.packed_byte)
            flag_error("packed_byte", want.packed_byte, result.packed_byte);
          if (result.byte_valid !== want.byte_valid)
            flag_error("byte_valid", want.byte_valid, result.byte_valid);
          if (result.index !== want.index)
            flag_error("index", want.index, result.index);
          if (result.found !== want.found)
            flag_error("found", want.found, result.found);
          if (result.new_entry !== want.new_entry)
            flag_error("new_entry", want.new_entry, result.new_entry);
          if (result.overflow !== want.overflow)
            flag_error("overflow", want.overflow, result.overflow);
          if (result.color_count !== want.color_count)
            flag_error("color_count", want.color_count, result.color_count);
          if (result.red !== want.red)
            flag_error("red", want.red, result.red);
          if (result.green !== want.green)
            flag_error("green", want.green, result.green);
          if (result.blue !== want.blue)
            flag_error("blue", want.blue, result.blue);
        end
      end
      if (item_valid && !item_stall) begin
        expected_results.insert(expected_results.size(), palette_step(item));
        item_taken = 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_palette_indexed_nibble_packer_core failed");
    $finish;
  end

  initial begin
    int unsigned                  pick;
    logic [pinp_pkg::COLOR_W-1:0] c;
    int                           n;
    bit                           drain;

    // empty palette, nothing pending
    add_item(pinp_pkg::KIND_READ,   24'h000000, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_FLUSH,  24'hFFFFFF, 4'hF, 1'b0);
    add_item(pinp_pkg::KIND_ENCODE, 24'h123456, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_FLUSH,  24'h000000, 4'h5, 1'b0);
    // first entries, duplicate learn, a full byte
    add_item(pinp_pkg::KIND_LEARN,  24'h000000, 4'hF, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'hFFFFFF, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'hFFFFFF, 4'hA, 1'b0);
    add_item(pinp_pkg::KIND_ENCODE, 24'hFFFFFF, 4'h3, 1'b0);
    add_item(pinp_pkg::KIND_ENCODE, 24'h000000, 4'hC, 1'b0);
    add_item(pinp_pkg::KIND_READ,   24'hFFFFFF, 4'h1, 1'b0);
    add_item(pinp_pkg::KIND_READ,   24'h000000, 4'hF, 1'b0);
    add_item(pinp_pkg::KIND_READ,   24'h5A5A5A, 4'h2, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'h0000FF, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'h00FF00, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'hFF0000, 4'h0, 1'b0);
    // learn and read while a nibble is pending
    add_item(pinp_pkg::KIND_ENCODE, 24'hFF0000, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_LEARN,  24'hABCDEF, 4'h7, 1'b0);
    add_item(pinp_pkg::KIND_READ,   24'h000000, 4'h4, 1'b0);
    add_item(pinp_pkg::KIND_READ,   24'hA5A5A5, 4'h5, 1'b0);
    add_item(pinp_pkg::KIND_FLUSH,  24'h000000, 4'h0, 1'b0);
    // unmatched color in the high nibble
    add_item(pinp_pkg::KIND_ENCODE, 24'h00FF00, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_ENCODE, 24'h654321, 4'h0, 1'b0);
    add_item(pinp_pkg::KIND_FLUSH,  24'h000000, 4'h0, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick  = $urandom_range(0, 99);
      c     = any_color();
      drain = (n % DRAIN_EVERY == DRAIN_EVERY - 1);
      if (pick < 25) begin
        if ($urandom_range(0, 99) >= 35)
          c = learn_pool[$urandom_range(0, learn_pool.size() - 1)];
        add_item(pinp_pkg::KIND_LEARN, c, pinp_pkg::ENTRY_W'($urandom), drain);
      end else if (pick < 68) begin
        if ($urandom_range(0, 99) < 80)
          c = learn_pool[$urandom_range(0, learn_pool.size() - 1)];
        add_item(pinp_pkg::KIND_ENCODE, c, pinp_pkg::ENTRY_W'($urandom), drain);
      end else if (pick < 80) begin
        add_item(pinp_pkg::KIND_FLUSH, c, pinp_pkg::ENTRY_W'($urandom), drain);
      end else begin
        add_item(pinp_pkg::KIND_READ, c, pinp_pkg::ENTRY_W'($urandom), drain);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (item_queue.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_palette_indexed_nibble_packer_core passed");
    end else begin
      $display("tb_palette_indexed_nibble_packer_core failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pinp_pkg.sv
sv/pinp_palette.sv
sv/pinp_packer.sv
sv/palette_indexed_nibble_packer_core.sv
tb/sv/tb_palette_indexed_nibble_packer_core.sv
